// ===== src/ucs2_to_utf8_encoder_unit_macros.svh =====
// Assertion macros used by the checker of the encoder.
`ifndef UCS2_TO_UTF8_ENCODER_UNIT_MACROS_SVH
`define UCS2_TO_UTF8_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define U8E_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("encoder check failed");

// Next-cycle implication, disabled while reset is low.
`define U8E_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("encoder check failed");

`endif

// ===== src/u8e_pkg.sv =====
`timescale 1ns / 1ps

package u8e_pkg;

    localparam int unsigned CodeW   = 16;
    localparam int unsigned ByteW   = 8;
    localparam int unsigned LenW    = 16;
    localparam int unsigned StatusW = 2;

    localparam logic [LenW-1:0] BufferSizeReset = 16'hffff;

    // Result status codes.
    typedef enum logic [StatusW-1:0] {
        ST_DATA     = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // All results caused by one code unit.
    typedef struct packed {
        logic [ByteW-1:0] b0;
        logic [ByteW-1:0] b1;
        logic [ByteW-1:0] b2;
        logic [1:0]       cnt;
        t_status          status;
        logic [LenW-1:0]  len;
    } t_group;

endpackage

// ===== src/ucs2_to_utf8_encoder_unit.sv =====
`timescale 1ns / 1ps
// Channel      | Direction | Handshake           | Payload
// -------------+-----------+---------------------+---------------------------------------------
// code unit in | input     | i_valid / o_ready   | i_code_unit
// result out   | output    | o_valid / i_ready   | o_out_byte, o_byte_valid, o_status,
//              |           |                     | o_string_length, o_last
// buffer size  | input     | i_buffer_size_we    | i_buffer_size (no wait, no read-back)
//
// A code unit is sent as one result per transfer: one for ASCII, a terminator or an overflow
// report, two or three for longer characters, so the one-byte output channel sets the rate.
// Code units dropped after an overflow send nothing and retire without waiting for the output.
// The next code unit is taken into the input register while the current one is being sent.
// Reset is synchronous and active low: byte count, discard flag and stage valids clear, and
// the buffer size returns to 65535. o_ready falls only when both stages are full.

module ucs2_to_utf8_encoder_unit
    import u8e_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration
    input  logic                 i_buffer_size_we,
    input  logic [LenW-1:0]      i_buffer_size,
    // Code unit channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [CodeW-1:0]     i_code_unit,
    // Result channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [ByteW-1:0]     o_out_byte,
    output logic                 o_byte_valid,
    output logic [StatusW-1:0]   o_status,
    output logic [LenW-1:0]      o_string_length,
    output logic                 o_last
);

    // Configuration and string state.
    logic [LenW-1:0]  r_buffer_size;
    logic [LenW-1:0]  r_bytes_written, n_bytes_written;
    logic             r_discarding, n_discarding;

    // Input register: the code unit being encoded.
    logic             r_s1_valid, n_s1_valid;
    logic [CodeW-1:0] r_code;

    // Result register: the group of results being sent, one per transfer.
    logic             r_s2_valid, n_s2_valid;
    t_group           r_grp, n_grp;
    logic [1:0]       r_idx, n_idx;

    logic             w_s2_done;
    logic             w_s2_free;
    logic             w_s1_adv;
    logic [1:0]       w_cnt;
    logic [LenW:0]    w_sum;
    logic             w_char_fits;
    logic             w_term_fits;
    logic             w_is_term;
    t_group           w_grp;

    // The last result of the group leaves this cycle, so the result register
    // can take the next group in the same edge.
    assign w_s2_done = r_s2_valid && i_ready && o_last;
    assign w_s2_free = !r_s2_valid || w_s2_done;
    // While discarding, a code unit produces nothing and retires at once.
    assign w_s1_adv  = r_s1_valid && (r_discarding || w_s2_free);
    assign o_ready   = !r_s1_valid || w_s1_adv;

    // Encoding of the held code unit.
    assign w_is_term = (r_code == '0);

    always_comb begin
        if (r_code[CodeW-1:7] == '0) begin
            w_cnt = 2'd1;
        end else if (r_code[CodeW-1:11] == '0) begin
            w_cnt = 2'd2;
        end else begin
            w_cnt = 2'd3;
        end
    end

    assign w_sum       = {1'b0, r_bytes_written} + {{(LenW - 1){1'b0}}, w_cnt};
    assign w_char_fits = (w_sum <= {1'b0, r_buffer_size});
    assign w_term_fits = (r_bytes_written < r_buffer_size);

    always_comb begin
        w_grp        = '0;
        w_grp.cnt    = 2'd1;
        w_grp.status = ST_DATA;
        if (w_is_term) begin
            if (w_term_fits) begin
                w_grp.status = ST_COMPLETE;
                w_grp.len    = r_bytes_written;
            end else begin
                w_grp.status = ST_OVERFLOW;
            end
        end else if (!w_char_fits) begin
            w_grp.status = ST_OVERFLOW;
        end else begin
            w_grp.cnt = w_cnt;
            unique case (w_cnt)
                2'd1: begin
                    w_grp.b0 = r_code[ByteW-1:0];
                end
                2'd2: begin
                    w_grp.b0 = {3'b110, r_code[10:6]};
                    w_grp.b1 = {2'b10, r_code[5:0]};
                end
                default: begin
                    w_grp.b0 = {4'b1110, r_code[15:12]};
                    w_grp.b1 = {2'b10, r_code[11:6]};
                    w_grp.b2 = {2'b10, r_code[5:0]};
                end
            endcase
        end
    end

    // Next-state logic for the string state and both stages.
    always_comb begin
        n_bytes_written = r_bytes_written;
        n_discarding    = r_discarding;
        n_s1_valid      = r_s1_valid;
        n_s2_valid      = r_s2_valid;
        n_grp           = r_grp;
        n_idx           = r_idx;

        if (w_s1_adv) begin
            if (r_discarding) begin
                if (w_is_term) begin
                    n_discarding    = 1'b0;
                    n_bytes_written = '0;
                end
            end else if (w_is_term) begin
                n_bytes_written = '0;
            end else if (!w_char_fits) begin
                n_discarding = 1'b1;
            end else begin
                n_bytes_written = w_sum[LenW-1:0];
            end
        end

        if (w_s1_adv && !r_discarding) begin
            n_s2_valid = 1'b1;
            n_grp      = w_grp;
            n_idx      = 2'd0;
        end else if (w_s2_done) begin
            n_s2_valid = 1'b0;
        end else if (r_s2_valid && i_ready) begin
            n_idx = r_idx + 2'd1;
        end

        if (i_valid && o_ready) begin
            n_s1_valid = 1'b1;
        end else if (w_s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size   <= BufferSizeReset;
            r_bytes_written <= '0;
            r_discarding    <= 1'b0;
            r_s1_valid      <= 1'b0;
            r_s2_valid      <= 1'b0;
            r_idx           <= 2'd0;
        end else begin
            if (i_buffer_size_we) begin
                r_buffer_size <= i_buffer_size;
            end
            r_bytes_written <= n_bytes_written;
            r_discarding    <= n_discarding;
            r_s1_valid      <= n_s1_valid;
            r_s2_valid      <= n_s2_valid;
            r_idx           <= n_idx;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_code <= i_code_unit;
        end
        r_grp <= n_grp;
    end

    // Result channel outputs, one byte of the group per transfer.
    always_comb begin
        unique case (r_idx)
            2'd0:    o_out_byte = r_grp.b0;
            2'd1:    o_out_byte = r_grp.b1;
            default: o_out_byte = r_grp.b2;
        endcase
    end

    assign o_valid         = r_s2_valid;
    assign o_byte_valid    = (r_grp.status != ST_OVERFLOW);
    assign o_status        = r_grp.status;
    assign o_string_length = r_grp.len;
    assign o_last          = ((r_idx + 2'd1) == r_grp.cnt);

endmodule

// ===== src/u8e_checker.sv =====
`timescale 1ns / 1ps
`include "ucs2_to_utf8_encoder_unit_macros.svh"

module u8e_checker
    import u8e_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic [ByteW-1:0]   o_out_byte,
    input logic               o_byte_valid,
    input logic [StatusW-1:0] o_status,
    input logic [LenW-1:0]    o_string_length,
    input logic               o_last
);

    logic                     w_is_ovf;
    logic                     w_is_cmp;
    logic                     w_is_data;
    logic                     w_ovf_ok;
    logic                     w_cmp_ok;
    logic                     w_data_ok;
    logic                     w_stall;
    logic [ByteW+StatusW:0]   w_view;

    assign w_is_ovf  = o_valid && (o_status == ST_OVERFLOW);
    assign w_is_cmp  = o_valid && (o_status == ST_COMPLETE);
    assign w_is_data = o_valid && (o_status == ST_DATA);
    assign w_stall   = o_valid && !i_ready;
    assign w_view    = {o_out_byte, o_status, o_last};

    // An overflow report carries no byte and ends its code unit's results.
    assign w_ovf_ok  = !o_byte_valid && (o_out_byte == '0) && o_last && (o_string_length == '0);
    // Completion carries the zero terminator as a stored byte.
    assign w_cmp_ok  = o_byte_valid && (o_out_byte == '0) && o_last;
    // A data byte is stored and reports no length; a non-final one is a lead byte
    // or a continuation byte, never ASCII.
    assign w_data_ok = o_byte_valid && (o_string_length == '0) && (o_last || o_out_byte[ByteW-1]);

    `U8E_ASSERT_NOW(a_overflow_form, i_clk, i_rst_n, w_is_ovf, w_ovf_ok)
    `U8E_ASSERT_NOW(a_complete_form, i_clk, i_rst_n, w_is_cmp, w_cmp_ok)
    `U8E_ASSERT_NOW(a_data_form, i_clk, i_rst_n, w_is_data, w_data_ok)

    // A stalled result holds.
    `U8E_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, w_stall, o_valid && $stable(w_view))

endmodule

bind ucs2_to_utf8_encoder_unit u8e_checker u_u8e_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_out_byte      (o_out_byte),
    .o_byte_valid    (o_byte_valid),
    .o_status        (o_status),
    .o_string_length (o_string_length),
    .o_last          (o_last)
);
